### hw/rtl/dms_pkg.sv
`timescale 1ns / 1ps

package dms_pkg;

  // Width of the saturating millisecond timer.
  localparam int unsigned TimerBits = 20;
  // Width of the timeout registers.
  localparam int unsigned TimeoutBits = 20;
  // Compare width that holds both the timer and a timeout.
  localparam int unsigned CmpBits = (TimerBits > TimeoutBits) ? TimerBits : TimeoutBits;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 20;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CfgTickMs          = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgConnectTimeout  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgPairingTimeout  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgTransmitTimeout = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgBlinkPeriod     = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [7:0]             TickMsReset          = 8'd10;
  localparam logic [TimeoutBits-1:0] ConnectTimeoutReset  = 20'd20000;
  localparam logic [TimeoutBits-1:0] PairingTimeoutReset  = 20'd20000;
  localparam logic [TimeoutBits-1:0] TransmitTimeoutReset = 20'd60000;
  localparam logic [7:0]             BlinkPeriodReset     = 8'd200;

  // Link status codes.
  localparam logic [1:0] LinkOther     = 2'd0;
  localparam logic [1:0] LinkSleep     = 2'd1;
  localparam logic [1:0] LinkConnected = 2'd2;
  localparam logic [1:0] LinkBulk      = 2'd3;

  // Mode codes as seen on the result word.
  localparam logic [2:0] CodeInitial   = 3'd0;
  localparam logic [2:0] CodeWps       = 3'd1;
  localparam logic [2:0] CodeDefaultAp = 3'd2;
  localparam logic [2:0] CodeReady     = 3'd3;
  localparam logic [2:0] CodeRecord    = 3'd4;
  localparam logic [2:0] CodeConnect   = 3'd5;
  localparam logic [2:0] CodeTransmit  = 3'd6;
  localparam logic [2:0] CodeFault     = 3'd7;

  typedef enum logic [7:0] {
    MODE_INITIAL    = 8'b0000_0001,
    MODE_WPS        = 8'b0000_0010,
    MODE_DEFAULT_AP = 8'b0000_0100,
    MODE_READY      = 8'b0000_1000,
    MODE_RECORD     = 8'b0001_0000,
    MODE_CONNECT    = 8'b0010_0000,
    MODE_TRANSMIT   = 8'b0100_0000,
    MODE_FAULT      = 8'b1000_0000
  } mode_e;

  typedef struct packed {
    logic [1:0] link_status;
    logic       main_button_short;
    logic       main_button_long;
    logic       record_button_short;
    logic       sampling_busy;
  } in_word_t;

  typedef struct packed {
    logic [2:0] mode_now;
    logic       led_operation;
    logic       led_link;
    logic       led_activity;
    logic       pulse_led_off;
    logic       start_pairing;
    logic       start_default_ap;
    logic       start_sampling;
    logic       reset_request;
  } out_word_t;

  typedef struct packed {
    logic [7:0]             tick_ms;
    logic [TimeoutBits-1:0] connect_timeout_ms;
    logic [TimeoutBits-1:0] pairing_timeout_ms;
    logic [TimeoutBits-1:0] transmit_timeout_ms;
    logic [7:0]             blink_period_ms;
  } cfg_t;

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] code;
    unique case (m)
      MODE_INITIAL:    code = CodeInitial;
      MODE_WPS:        code = CodeWps;
      MODE_DEFAULT_AP: code = CodeDefaultAp;
      MODE_READY:      code = CodeReady;
      MODE_RECORD:     code = CodeRecord;
      MODE_CONNECT:    code = CodeConnect;
      MODE_TRANSMIT:   code = CodeTransmit;
      MODE_FAULT:      code = CodeFault;
      default:         code = CodeInitial;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/dms_cfg_regs.sv
`timescale 1ns / 1ps

module dms_cfg_regs import dms_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTickMs:          cfg_d.tick_ms             = cfg_wdata_i[7:0];
        CfgConnectTimeout:  cfg_d.connect_timeout_ms  = cfg_wdata_i[TimeoutBits-1:0];
        CfgPairingTimeout:  cfg_d.pairing_timeout_ms  = cfg_wdata_i[TimeoutBits-1:0];
        CfgTransmitTimeout: cfg_d.transmit_timeout_ms = cfg_wdata_i[TimeoutBits-1:0];
        CfgBlinkPeriod:     cfg_d.blink_period_ms     = cfg_wdata_i[7:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_ms             <= TickMsReset;
      cfg_q.connect_timeout_ms  <= ConnectTimeoutReset;
      cfg_q.pairing_timeout_ms  <= PairingTimeoutReset;
      cfg_q.transmit_timeout_ms <= TransmitTimeoutReset;
      cfg_q.blink_period_ms     <= BlinkPeriodReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/dms_seq_core.sv
`timescale 1ns / 1ps

module dms_seq_core import dms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      step_i,
  input  in_word_t  word_i,
  output out_word_t word_o
);

  typedef logic [CmpBits-1:0] cmp_t;

  localparam logic [TimerBits-1:0] TimerMax = {TimerBits{1'b1}};

  mode_e                mode_d, mode_q;
  logic [TimerBits-1:0] timer_d, timer_q;
  logic [7:0]           phase_d, phase_q;

  logic [TimerBits:0]   timer_sum;
  logic [TimerBits-1:0] timer_sat;
  logic [8:0]           phase_sum;
  logic                 bright;
  logic                 linked;
  logic                 conn_to, pair_to, xmit_to;

  // Saturating timer add.
  always_comb begin
    timer_sum = {1'b0, timer_q} + (TimerBits+1)'(cfg_i.tick_ms);
    timer_sat = timer_sum[TimerBits] ? TimerMax : timer_sum[TimerBits-1:0];
  end

  assign conn_to = cmp_t'(timer_sat) >= cmp_t'(cfg_i.connect_timeout_ms);
  assign pair_to = cmp_t'(timer_sat) >= cmp_t'(cfg_i.pairing_timeout_ms);
  assign xmit_to = cmp_t'(timer_sat) >= cmp_t'(cfg_i.transmit_timeout_ms);

  // Blink phase: wrap with one compare and subtract.
  always_comb begin
    bright    = phase_q < {1'b0, cfg_i.blink_period_ms[7:1]};
    phase_sum = {1'b0, phase_q} + {1'b0, cfg_i.tick_ms};
    if (phase_sum >= {1'b0, cfg_i.blink_period_ms}) begin
      phase_sum = phase_sum - {1'b0, cfg_i.blink_period_ms};
    end
    phase_d = phase_sum[7:0];
  end

  assign linked = (word_i.link_status == LinkSleep) || (word_i.link_status == LinkConnected);

  always_comb begin
    word_o               = '0;
    word_o.led_operation = 1'b1;
    mode_d               = mode_q;

    // LEDs follow the mode held before this word.
    unique case (mode_q)
      MODE_WPS, MODE_DEFAULT_AP: word_o.led_link = bright;
      MODE_READY:                word_o.led_link = 1'b1;
      MODE_RECORD: begin
        word_o.led_link     = 1'b1;
        word_o.led_activity = 1'b1;
      end
      MODE_CONNECT, MODE_TRANSMIT: begin
        word_o.led_link     = 1'b1;
        word_o.led_activity = bright;
      end
      MODE_FAULT: begin
        word_o.led_operation = bright;
        word_o.pulse_led_off = 1'b1;
      end
      default: word_o.led_operation = 1'b1;
    endcase

    // Later rules override earlier ones; timeout last.
    unique case (mode_q)
      MODE_INITIAL: begin
        if (linked) mode_d = MODE_READY;
        if (word_i.main_button_short) begin
          word_o.start_pairing = 1'b1;
          mode_d               = MODE_WPS;
        end
        if (word_i.main_button_long) begin
          word_o.start_default_ap = 1'b1;
          mode_d                  = MODE_DEFAULT_AP;
        end
        if (conn_to) mode_d = MODE_FAULT;
      end
      MODE_WPS, MODE_DEFAULT_AP: begin
        if (linked) mode_d = MODE_READY;
        if (pair_to) mode_d = MODE_FAULT;
      end
      MODE_READY: begin
        if ((word_i.link_status == LinkSleep) && word_i.record_button_short) begin
          word_o.start_sampling = 1'b1;
          mode_d                = MODE_RECORD;
        end
      end
      MODE_RECORD: begin
        if (!word_i.sampling_busy) mode_d = MODE_CONNECT;
      end
      MODE_CONNECT: begin
        if (word_i.link_status == LinkBulk) mode_d = MODE_TRANSMIT;
        if (conn_to) mode_d = MODE_FAULT;
      end
      MODE_TRANSMIT: begin
        if (word_i.link_status != LinkBulk) mode_d = MODE_READY;
        if (xmit_to) mode_d = MODE_FAULT;
      end
      MODE_FAULT: begin
        if (word_i.main_button_short) word_o.reset_request = 1'b1;
      end
      default: mode_d = mode_q;
    endcase

    word_o.mode_now = mode_code(mode_d);
    // Clear the timer on any mode change.
    timer_d = (mode_d != mode_q) ? '0 : timer_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_INITIAL;
      timer_q <= '0;
      phase_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      timer_q <= timer_d;
      phase_q <= phase_d;
    end
  end

endmodule

### hw/rtl/device_mode_sequencer_unit.sv
`timescale 1ns / 1ps

// Mode sequencer for a wireless measuring device. Each input word is one
// periodic tick carrying link status, button events and the sampling-busy
// flag; each tick yields exactly one result word with the new mode, the LED
// pattern of the mode held before the tick, and the command pulses (WPS
// pairing, default access point, sampling start, system reset). A word is
// captured in an input register, evaluated in one pass of short logic
// against the mode, timer and blink-phase registers, and lands in an output
// register. One word is taken every cycle while the result register is not
// stalled; the mode, timer and phase registers update once for each word.
// Write configuration only while no word is in flight. The blink wrap uses a
// single subtract, so keep tick_ms no greater than blink_period_ms.

module device_mode_sequencer_unit import dms_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input words
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_word_t               in_word_i,
  // result words
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_word_t              out_word_o,
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  in_word_t  in_word_q;
  logic      in_valid_q;
  out_word_t out_word_q, res_word;
  logic      out_valid_q;
  logic      out_free;
  logic      step;
  logic      in_take;

  // Output register frees when empty or when its word leaves this cycle.
  assign out_free = !out_valid_q || !out_stall_i;
  // Advance the held input word into the result register.
  assign step     = in_valid_q && out_free;
  // Hold the input register only while its word cannot move on.
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  dms_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  dms_seq_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .step_i(step),
    .word_i(in_word_q),
    .word_o(res_word)
  );

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input payload: capture on accept only.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
  end

  // Result register control: fill on step, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
